FILE: rtl/nsbr_pkg.sv
// Shared types and constants for the nearest-neighbor scaler with RGB565 packing.
`default_nettype none

package nsbr_pkg;

  localparam int SRC_PIXELS_DEF  = 32768;
  localparam int MAX_DST_DIM_DEF = 1024;
  localparam int DIM_LIMIT       = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Source index width: 256 columns by 128 rows.
  localparam int IDX_W = 15;
  // Quotient width of the scale dividers (source column below 256).
  localparam int Q_W   = 8;
  localparam int DEN_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_DST_WIDTH   = 3'd2,
    REG_DST_HEIGHT  = 3'd3,
    REG_PITCH_WORDS = 3'd4
  } reg_idx_t;

  // Configuration after saturation into the legal ranges.
  typedef struct packed {
    logic [8:0]  sw;
    logic [7:0]  sh;
    logic [10:0] dw;
    logic [10:0] dh;
    logic [11:0] pw;
    logic [15:0] total;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic emit;
    logic prep;
    logic idx;
    logic mod_step;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mod_done;
    logic out_free;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_IDX,
    ST_MOD,
    ST_RD,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/nearest_scale_bgr_to_rgb565.sv
// Top level of the nearest-neighbor scaler with RGB565 packing.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    req_type, red, green, blue
//   out_      output     out_valid / out_ready  pixel_rgb565, fb_address, frame_last
//   cfg_      input      cfg_valid / cfg_ready  index, data (12 bits)
//
// Loads are accepted only in the idle state, so they stream at one per clock while no
// emit is in progress. An emit transaction holds in_ready low once taken, through the
// prep state that registers the framebuffer address and starts the two 8-step restoring
// dividers (column and row run side by side), the index multiply, the modulo state with
// one shifted subtract per step when the frame store holds fewer than 32768 words, the
// registered store read and the output load; no new transaction is taken until the emit
// is through. A finished result waits in the output register while loads keep flowing;
// a further emit stalls before its output load until that result is taken. Reset is
// synchronous and clears the pointers and the raster position; the frame store is not
// cleared.
`default_nettype none

module nearest_scale_bgr_to_rgb565
  import nsbr_pkg::*;
#(
  parameter int SRC_PIXELS  = SRC_PIXELS_DEF,
  parameter int MAX_DST_DIM = MAX_DST_DIM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [7:0]            in_red,
  input  wire logic [7:0]            in_green,
  input  wire logic [7:0]            in_blue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                out_pixel_rgb565,
  output logic [20:0]                out_fb_address,
  output logic                       out_frame_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_CAP = (MAX_DST_DIM < DIM_LIMIT) ? MAX_DST_DIM : DIM_LIMIT;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  nsbr_cfg #(
    .DIM_CAP (DIM_CAP)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nsbr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  nsbr_dp #(
    .SRC_PIXELS  (SRC_PIXELS),
    .MAX_DST_DIM (MAX_DST_DIM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_pixel_rgb565 (out_pixel_rgb565),
    .out_fb_address   (out_fb_address),
    .out_frame_last   (out_frame_last)
  );

endmodule

`default_nettype wire

FILE: rtl/nsbr_cfg.sv
// Configuration registers with range saturation and source pixel count.
`default_nettype none

module nsbr_cfg
  import nsbr_pkg::*;
#(
  parameter int DIM_CAP = DIM_LIMIT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [8:0]  src_width_r;
  logic [7:0]  src_height_r;
  logic [10:0] dst_width_r;
  logic [10:0] dst_height_r;
  logic [11:0] pitch_words_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r   <= 9'd160;
      src_height_r  <= 8'd120;
      dst_width_r   <= 11'd240;
      dst_height_r  <= 11'd320;
      pitch_words_r <= 12'd240;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_SRC_WIDTH:   src_width_r   <= cfg_data[8:0];
        REG_SRC_HEIGHT:  src_height_r  <= cfg_data[7:0];
        REG_DST_WIDTH:   dst_width_r   <= cfg_data[10:0];
        REG_DST_HEIGHT:  dst_height_r  <= cfg_data[10:0];
        REG_PITCH_WORDS: pitch_words_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Zero counts as one and anything too large counts as the maximum.
  always_comb begin
    cfg.sw = (src_width_r == 9'd0) ? 9'd1 :
             (src_width_r > 9'd256) ? 9'd256 : src_width_r;
    cfg.sh = (src_height_r == 8'd0) ? 8'd1 :
             (src_height_r > 8'd128) ? 8'd128 : src_height_r;
    cfg.dw = (dst_width_r == 11'd0) ? 11'd1 :
             (dst_width_r > 11'(DIM_CAP)) ? 11'(DIM_CAP) : dst_width_r;
    cfg.dh = (dst_height_r == 11'd0) ? 11'd1 :
             (dst_height_r > 11'(DIM_CAP)) ? 11'(DIM_CAP) : dst_height_r;
    cfg.pw = (pitch_words_r == 12'd0) ? 12'd1 :
             (pitch_words_r > 12'd2048) ? 12'd2048 : pitch_words_r;
    cfg.total = 16'(cfg.sw) * 16'(cfg.sh);
  end

endmodule

`default_nettype wire

FILE: rtl/nsbr_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module nsbr_div
  import nsbr_pkg::*;
#(
  parameter int NUM_W = 19,
  parameter int DV_W  = DEN_W,
  parameter int QB_W  = Q_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DV_W-1:0]  den,
  output logic      [QB_W-1:0]  quot,
  output logic                  done
);

  localparam int W  = (NUM_W > DV_W + QB_W - 1) ? NUM_W : DV_W + QB_W - 1;
  localparam int CW = $clog2(QB_W + 1);

  logic [W-1:0]    rem_r;
  logic [W-1:0]    dsh_r;
  logic [QB_W-1:0] q_r;
  logic [CW-1:0]   cnt_r;
  logic            fits;

  // The quotient is known to fit in QB_W bits, so the divisor starts
  // shifted by QB_W-1 places and moves right one place per step.
  assign fits = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(QB_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= W'(num);
      dsh_r <= W'(den) << (QB_W - 1);
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= (q_r << 1) | QB_W'(fits);
      dsh_r <= dsh_r >> 1;
    end
  end

  assign quot = q_r;
  assign done = (cnt_r == '0);

endmodule

`default_nettype wire

FILE: rtl/nsbr_ctrl.sv
// Controller state machine that sequences load and emit transactions.
`default_nettype none

module nsbr_ctrl
  import nsbr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_req_type,
  output logic       in_ready,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type) begin
            cmd.emit  = 1'b1;
            state_nxt = ST_PREP;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_IDX;
        end
      end
      ST_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          state_nxt = ST_RD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/nsbr_dp.sv
// Datapath: frame store, load pointer, output raster, scale dividers and output register.
`default_nettype none

module nsbr_dp
  import nsbr_pkg::*;
#(
  parameter int SRC_PIXELS  = SRC_PIXELS_DEF,
  parameter int MAX_DST_DIM = MAX_DST_DIM_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire cmd_t       cmd,
  output stat_t           stat,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [15:0]     out_pixel_rgb565,
  output logic [20:0]     out_fb_address,
  output logic            out_frame_last
);

  localparam int DIM_CAP   = (MAX_DST_DIM < DIM_LIMIT) ? MAX_DST_DIM : DIM_LIMIT;
  localparam int POS_W     = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
  localparam int AW        = (SRC_PIXELS > 1) ? $clog2(SRC_PIXELS) : 1;
  localparam int NUM_W     = POS_W + 9;
  localparam int FB_W      = POS_W + 13;
  localparam int SPAN      = 1 << IDX_W;
  localparam int QMAX      = (SRC_PIXELS < SPAN) ? (SPAN - 1) / SRC_PIXELS : 0;
  localparam int MOD_STEPS = $clog2(QMAX + 1);
  localparam int MS_W      = (MOD_STEPS > 0) ? $clog2(MOD_STEPS + 1) : 1;
  localparam int MOD_C     = (SRC_PIXELS < SPAN) ? SRC_PIXELS : 1;

  logic [15:0] mem [SRC_PIXELS];

  logic [IDX_W-1:0] load_ptr_r;
  logic [AW-1:0]    load_addr_r;
  logic [POS_W-1:0] col_r;
  logic [POS_W-1:0] row_r;
  logic [POS_W-1:0] cur_col_r;
  logic [POS_W-1:0] cur_row_r;
  logic             last_r;
  logic [20:0]      fb_r;
  logic [IDX_W-1:0] rem_r;
  logic [MS_W-1:0]  mod_left_r;
  logic [15:0]      rd_data_r;
  logic             out_valid_r;
  logic [15:0]      out_pix_r;
  logic [20:0]      out_addr_r;
  logic             out_last_r;

  // Load pointer handling.
  logic             ptr_wrap;
  logic [IDX_W-1:0] ptr_eff;
  logic [AW-1:0]    addr_eff;
  logic [15:0]      ptr_inc;
  logic             ptr_end;
  logic [IDX_W-1:0] ptr_nxt;
  logic [AW-1:0]    addr_nxt;
  logic [15:0]      pix565;

  assign pix565   = {in_red[7:3], in_green[7:2], in_blue[7:3]};
  assign ptr_wrap = ({1'b0, load_ptr_r} >= cfg.total);
  assign ptr_eff  = ptr_wrap ? '0 : load_ptr_r;
  assign addr_eff = ptr_wrap ? '0 : load_addr_r;
  assign ptr_inc  = {1'b0, ptr_eff} + 16'd1;
  assign ptr_end  = (ptr_inc >= cfg.total);
  assign ptr_nxt  = ptr_end ? '0 : ptr_inc[IDX_W-1:0];

  // The store address follows the pointer modulo the store depth.
  always_comb begin
    if (ptr_end || addr_eff == AW'(SRC_PIXELS - 1)) begin
      addr_nxt = '0;
    end else begin
      addr_nxt = addr_eff + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r  <= '0;
      load_addr_r <= '0;
    end else if (cmd.load) begin
      load_ptr_r  <= ptr_nxt;
      load_addr_r <= addr_nxt;
    end
  end

  // Output raster; a position left out of range by a register change restarts at zero.
  logic [POS_W-1:0] col_eff;
  logic [POS_W-1:0] row_eff;
  logic             last_col;
  logic             last_row;
  logic [POS_W-1:0] col_nxt;
  logic [POS_W-1:0] row_nxt;

  assign col_eff  = (11'(col_r) >= cfg.dw) ? '0 : col_r;
  assign row_eff  = (11'(row_r) >= cfg.dh) ? '0 : row_r;
  assign last_col = (11'(col_eff) == cfg.dw - 11'd1);
  assign last_row = (11'(row_eff) == cfg.dh - 11'd1);

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_eff + POS_W'(1);
    end else begin
      col_nxt = col_eff + POS_W'(1);
      row_nxt = row_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.emit) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cur_col_r <= col_eff;
      cur_row_r <= row_eff;
      last_r    <= last_col & last_row;
    end
  end

  // Scale products and framebuffer address.
  logic [NUM_W-1:0] num_x;
  logic [NUM_W-1:0] num_y;
  logic [FB_W-1:0]  fb_sum;
  logic [Q_W-1:0]   q_x;
  logic [Q_W-1:0]   q_y;
  logic             done_x;
  logic             done_y;

  assign num_x  = NUM_W'(cur_col_r) * NUM_W'(cfg.sw);
  assign num_y  = NUM_W'(cur_row_r) * NUM_W'(cfg.sh);
  assign fb_sum = FB_W'(cur_row_r) * FB_W'(cfg.pw) + FB_W'(cur_col_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      fb_r <= 21'(fb_sum);
    end
  end

  nsbr_div #(
    .NUM_W (NUM_W),
    .DV_W  (DEN_W),
    .QB_W  (Q_W)
  ) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.prep),
    .num   (num_x),
    .den   (cfg.dw),
    .quot  (q_x),
    .done  (done_x)
  );

  nsbr_div #(
    .NUM_W (NUM_W),
    .DV_W  (DEN_W),
    .QB_W  (Q_W)
  ) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.prep),
    .num   (num_y),
    .den   (cfg.dh),
    .quot  (q_y),
    .done  (done_y)
  );

  // Source index, then reduction modulo the store depth one shifted subtract per cycle.
  logic [16:0]     idx_sum;
  logic [MS_W-1:0] mod_sh;
  logic [15:0]     mod_sub;
  logic [AW-1:0]   rd_addr;

  assign idx_sum = 17'(q_y) * 17'(cfg.sw) + 17'(q_x);
  assign mod_sh  = mod_left_r - MS_W'(1);
  assign mod_sub = 16'(MOD_C) << mod_sh;
  assign rd_addr = AW'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_left_r <= '0;
    end else if (cmd.idx) begin
      mod_left_r <= MS_W'(MOD_STEPS);
    end else if (cmd.mod_step) begin
      mod_left_r <= mod_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx) begin
      rem_r <= idx_sum[IDX_W-1:0];
    end else if (cmd.mod_step && 16'(rem_r) >= mod_sub) begin
      rem_r <= rem_r - IDX_W'(mod_sub);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[addr_eff] <= pix565;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pix_r  <= rd_data_r;
      out_addr_r <= fb_r;
      out_last_r <= last_r;
    end
  end

  assign stat.div_done = done_x & done_y;
  assign stat.mod_done = (mod_left_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_pixel_rgb565 = out_pix_r;
  assign out_fb_address   = out_addr_r;
  assign out_frame_last   = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/nsbr_checker.sv
// Port-level checks for the scaler, bound to the top level.
`default_nettype none

module nsbr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_req_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_pixel_rgb565,
  input wire logic [20:0] out_fb_address,
  input wire logic        out_frame_last
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_rgb565) &&
      $stable(out_fb_address) && $stable(out_frame_last))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A load transaction never creates a result.
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_req_type && !out_valid |=> !out_valid)
    else $error("load transaction produced a result");

  // An emit transaction drops input ready once it is taken.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type |=> !in_ready)
    else $error("input ready right after an emit transaction");

endmodule

bind nearest_scale_bgr_to_rgb565 nsbr_checker u_nsbr_checker (.*);

`default_nettype wire

FILE: sim/tb_nearest_scale_bgr_to_rgb565.sv
// Self-checking testbench for the nearest-neighbor scaler with RGB565 packing.
`default_nettype none

module tb_nearest_scale_bgr_to_rgb565;
  import nsbr_pkg::*;

  localparam bit REQ_LOAD = 1'b0;
  localparam bit REQ_EMIT = 1'b1;
  localparam int STORE_WORDS = 32768;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT = 6;

  typedef struct packed {
    logic [15:0] pixel;
    logic [20:0] addr;
    logic        last;
  } scaled_px_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    int unsigned value;
    bit          req;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    bit          has_want;
    scaled_px_t  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [7:0]            in_red;
  logic [7:0]            in_green;
  logic [7:0]            in_blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [15:0]           out_pixel_rgb565;
  logic [20:0]           out_fb_address;
  logic                  out_frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  nearest_scale_bgr_to_rgb565 u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_rgb565 (out_pixel_rgb565),
    .out_fb_address   (out_fb_address),
    .out_frame_last   (out_frame_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Scaler shadow state: frame store, write pointer, raster position.
  logic [15:0] px_mem [STORE_WORDS];
  bit          px_written [STORE_WORDS];
  int unsigned wr_ptr;
  int unsigned ras_col;
  int unsigned ras_row;
  // Register values after saturation into their legal ranges.
  int unsigned sw_sat = 160;
  int unsigned sh_sat = 120;
  int unsigned dw_sat = 240;
  int unsigned dh_sat = 320;
  int unsigned pw_sat = 240;

  scaled_px_t pixels_due [$];
  stim_row_t  directed_rows [$];
  int         error_count;
  bit         tx_calm;
  bit         hold_req;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Store index that the next output pixel reads, after any raster restart.
  function automatic int unsigned source_index();
    int unsigned col;
    int unsigned row;
    col = (ras_col >= dw_sat) ? 0 : ras_col;
    row = (ras_row >= dh_sat) ? 0 : ras_row;
    return ((row * sh_sat / dh_sat) * sw_sat + col * sw_sat / dw_sat) % STORE_WORDS;
  endfunction

  function automatic bit scale_step(input bit req, input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, output scaled_px_t px);
    int unsigned total;
    total = sw_sat * sh_sat;
    px = '0;
    if (req == REQ_LOAD) begin
      if (wr_ptr >= total) wr_ptr = 0;
      px_mem[wr_ptr % STORE_WORDS] = {r[7:3], g[7:2], b[7:3]};
      px_written[wr_ptr % STORE_WORDS] = 1'b1;
      wr_ptr++;
      if (wr_ptr >= total) wr_ptr = 0;
      return 1'b0;
    end
    px.pixel = px_mem[source_index()];
    if (ras_col >= dw_sat) ras_col = 0;
    if (ras_row >= dh_sat) ras_row = 0;
    px.addr = 21'(ras_row * pw_sat + ras_col);
    px.last = (ras_col == dw_sat - 1) && (ras_row == dh_sat - 1);
    if (ras_col == dw_sat - 1) begin
      ras_col = 0;
      ras_row = (ras_row == dh_sat - 1) ? 0 : ras_row + 1;
    end else begin
      ras_col++;
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t item_row(bit req, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                         bit has_want = 1'b0, logic [15:0] pix = '0,
                                         logic [20:0] addr = '0, logic last = 1'b0);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.idx = REG_SRC_WIDTH;
    row.value = 0;
    row.req = req;
    row.r = r;
    row.g = g;
    row.b = b;
    row.has_want = has_want;
    row.want = '{pixel: pix, addr: addr, last: last};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(reg_idx_t idx, int unsigned value);
    stim_row_t row;
    row = item_row(REQ_LOAD, 8'h00, 8'h00, 8'h00);
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Drops valid, waits for every expected pixel, then lets the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    logic [11:0] data;
    data = 12'(value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SRC_WIDTH:   sw_sat = clip(int'(data[8:0]), 1, 256);
      REG_SRC_HEIGHT:  sh_sat = clip(int'(data[7:0]), 1, 128);
      REG_DST_WIDTH:   dw_sat = clip(int'(data[10:0]), 1, DIM_LIMIT);
      REG_DST_HEIGHT:  dh_sat = clip(int'(data[10:0]), 1, DIM_LIMIT);
      REG_PITCH_WORDS: pw_sat = clip(int'(data), 1, 2048);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one transaction, waits for acceptance and returns the predicted pixel.
  task automatic send_item(input bit req, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, output bit produced, output scaled_px_t px);
    while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (!in_ready);
    produced = scale_step(req, r, g, b, px);
  endtask

  task automatic send_checked(input bit req, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
    bit         produced;
    scaled_px_t px;
    send_item(req, r, g, b, produced, px);
    if (produced) pixels_due.push_back(px);
  endtask

  task automatic send_random(input int emit_pct);
    bit req;
    req = ($urandom_range(99) < emit_pct) ? REQ_EMIT : REQ_LOAD;
    // Never read a store word that has not been loaded since reset.
    if (req == REQ_EMIT && !px_written[source_index()]) req = REQ_LOAD;
    send_checked(req, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Stimulus
  initial begin
    bit          produced;
    scaled_px_t  px;
    int unsigned sw_raw;
    int unsigned sh_raw;
    int unsigned dw_raw;
    int unsigned dh_raw;
    int unsigned pw_raw;
    int unsigned pre_cap;
    int          n_items;
    int          emit_pct;
    int          rand_count;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_LOAD;
    in_red <= 8'h00;
    in_green <= 8'h00;
    in_blue <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SRC_WIDTH;
    cfg_data <= '0;
    error_count = 0;
    tx_calm = 1'b0;
    hold_req = 1'b0;
    wr_ptr = 0;
    ras_col = 0;
    ras_row = 0;
    rand_count = 0;

    // Two by one source, two by two raster, widest pitch.
    directed_rows.push_back(cfg_row(REG_SRC_WIDTH, 2));
    directed_rows.push_back(cfg_row(REG_SRC_HEIGHT, 1));
    directed_rows.push_back(cfg_row(REG_DST_WIDTH, 2));
    directed_rows.push_back(cfg_row(REG_DST_HEIGHT, 2));
    directed_rows.push_back(cfg_row(REG_PITCH_WORDS, 2048));
    directed_rows.push_back(item_row(REQ_LOAD, 8'hFF, 8'hFF, 8'hFF));
    directed_rows.push_back(item_row(REQ_LOAD, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'hFFFF, 21'd0, 0));
    directed_rows.push_back(item_row(REQ_EMIT, 8'hFF, 8'hFF, 8'hFF, 1, 16'h0000, 21'd1, 0));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'hFFFF, 21'd2048, 0));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'h0000, 21'd2049, 1));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'hFFFF, 21'd0, 0));
    // Single color channels at full scale; the low bits must be dropped.
    directed_rows.push_back(item_row(REQ_LOAD, 8'hF8, 8'h00, 8'h00));
    directed_rows.push_back(item_row(REQ_LOAD, 8'h00, 8'hFC, 8'h00));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'h07E0, 21'd1, 0));
    directed_rows.push_back(item_row(REQ_LOAD, 8'h00, 8'h00, 8'hF8));
    directed_rows.push_back(item_row(REQ_LOAD, 8'h07, 8'h03, 8'h07));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'h001F, 21'd2048, 0));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'h0000, 21'd2049, 1));
    directed_rows.push_back(item_row(REQ_LOAD, 8'h08, 8'h04, 8'h08));
    directed_rows.push_back(item_row(REQ_LOAD, 8'hAA, 8'h55, 8'h33));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'h0821, 21'd0, 0));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'h0821, 21'd2048, 0));
    // Zero registers count as one; the raster position now lies outside and restarts.
    directed_rows.push_back(cfg_row(REG_DST_WIDTH, 0));
    directed_rows.push_back(cfg_row(REG_DST_HEIGHT, 0));
    directed_rows.push_back(cfg_row(REG_PITCH_WORDS, 0));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'h0821, 21'd0, 1));
    // Shrinking the source leaves the load pointer outside the frame.
    directed_rows.push_back(item_row(REQ_LOAD, 8'h10, 8'h08, 8'h10));
    directed_rows.push_back(cfg_row(REG_SRC_WIDTH, 0));
    directed_rows.push_back(item_row(REQ_LOAD, 8'hFF, 8'h00, 8'hFF));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'hF81F, 21'd0, 1));
    // Oversized registers saturate to their maximum.
    directed_rows.push_back(cfg_row(REG_SRC_WIDTH, 511));
    directed_rows.push_back(cfg_row(REG_SRC_HEIGHT, 255));
    directed_rows.push_back(cfg_row(REG_DST_WIDTH, 2047));
    directed_rows.push_back(cfg_row(REG_DST_HEIGHT, 2047));
    directed_rows.push_back(cfg_row(REG_PITCH_WORDS, 4095));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'hF81F, 21'd0, 0));
    directed_rows.push_back(item_row(REQ_EMIT, 8'h00, 8'h00, 8'h00, 1, 16'hF81F, 21'd1, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_item(directed_rows[i].req, directed_rows[i].r, directed_rows[i].g,
                  directed_rows[i].b, produced, px);
        if (produced) pixels_due.push_back(directed_rows[i].has_want ? directed_rows[i].want : px);
      end
    end

    for (int p = 0; p < 11; p++) begin
      settle();
      case (p)
        0: begin
          // Tall raster: one full frame reaches the last row at the widest pitch.
          sw_raw = 1;
          sh_raw = 128;
          dw_raw = 1;
          dh_raw = 1024;
          pw_raw = 2048;
          pre_cap = 256;
          n_items = 1030;
          emit_pct = 100;
        end
        1: begin
          sw_raw = 256;
          sh_raw = 1;
          dw_raw = 2047;
          dh_raw = 1;
          pw_raw = $urandom_range(1, 2048);
          pre_cap = 64;
          n_items = 100;
          emit_pct = 90;
        end
        2: begin
          // Largest source frame; an emit whose source word is not loaded yet becomes a load.
          sw_raw = 256;
          sh_raw = 255;
          dw_raw = $urandom_range(1, 24);
          dh_raw = $urandom_range(1, 24);
          pw_raw = $urandom_range(1, 2048);
          pre_cap = 64;
          n_items = 100;
          emit_pct = 75;
        end
        default: begin
          sw_raw = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 0 : $urandom_range(257, 4095))
                                            : $urandom_range(1, 16);
          sh_raw = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 8);
          dw_raw = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 0 : $urandom_range(1025, 4095))
                                            : $urandom_range(1, 20);
          dh_raw = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 0 : $urandom_range(1025, 4095))
                                            : $urandom_range(1, 20);
          pw_raw = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 0 : $urandom_range(2049, 4095))
                                            : $urandom_range(1, 2048);
          pre_cap = 16;
          n_items = 30;
          emit_pct = 75;
        end
      endcase
      write_reg(REG_SRC_WIDTH, sw_raw);
      write_reg(REG_SRC_HEIGHT, sh_raw);
      write_reg(REG_DST_WIDTH, dw_raw);
      write_reg(REG_DST_HEIGHT, dh_raw);
      write_reg(REG_PITCH_WORDS, pw_raw);
      repeat ((sw_sat * sh_sat < pre_cap) ? sw_sat * sh_sat : pre_cap)
        send_checked(REQ_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      if (p == 3) hold_req = 1'b1;
      repeat (n_items) begin
        send_random(emit_pct);
        rand_count++;
        tx_calm = (rand_count >= 300 && rand_count < 700);
      end
    end

    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result sink: random stalls, one long hold-off, and a quiet stretch.
  initial begin
    int unsigned cycle_count;
    int unsigned hold_left;
    cycle_count = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (cycle_count % 20000 < 4000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : check_pixels
    scaled_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pixels_due.size() == 0) begin
        flag_mismatch("output transaction with no pixel expected");
      end else begin
        want = pixels_due.pop_front();
        if (out_pixel_rgb565 !== want.pixel)
          flag_mismatch($sformatf("pixel_rgb565 %h, expected %h", out_pixel_rgb565, want.pixel));
        if (out_fb_address !== want.addr)
          flag_mismatch($sformatf("fb_address %h, expected %h", out_fb_address, want.addr));
        if (out_frame_last !== want.last)
          flag_mismatch($sformatf("frame_last %b, expected %b", out_frame_last, want.last));
      end
    end
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/nsbr_pkg.sv
rtl/nsbr_cfg.sv
rtl/nsbr_div.sv
rtl/nsbr_ctrl.sv
rtl/nsbr_dp.sv
rtl/nearest_scale_bgr_to_rgb565.sv
rtl/nsbr_checker.sv
sim/tb_nearest_scale_bgr_to_rgb565.sv
